// File: rtl/core/rep_pkg.sv
// shared types and constants of the repeat event suppressor
`default_nettype none

package rep_pkg;

    localparam logic [31:0] FNV_OFFSET = 32'h811C_9DC5;
    localparam logic [31:0] FNV_PRIME  = 32'h0100_0193;

    localparam logic KIND_SUMMARY = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    typedef struct packed {
        logic        kind;
        logic        suppressed;
        logic [15:0] report_owner;
        logic [15:0] report_tag;
        logic [31:0] repeat_count;
        logic [31:0] event_sig;
        logic        last_result;
    } rep_result_t;

    typedef struct packed {
        logic take;
        logic fold_tag;
        logic fold_owner;
        logic idx_clear;
        logic idx_step;
        logic use_target;
        logic expire_free;
        logic look_step;
        logic fill;
        logic emit_summary;
        logic emit_verdict;
        logic flush;
        logic chain_done;
    } rep_cmd_t;

    typedef struct packed {
        logic in_valid;
        logic in_tick;
        logic is_tick;
        logic is_last;
        logic window_zero;
        logic idx_last;
        logic expire_hit;
        logic expire_report;
        logic look_match;
        logic target_report;
        logic emit_ok;
    } rep_status_t;

endpackage

`default_nettype wire

// File: rtl/core/rep_in_if.sv
// node channel interface
`default_nettype none

interface rep_in_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic [15:0] node_tag;
    logic [15:0] node_owner;
    logic        last_node;
    logic [31:0] now;

    modport source (
        output valid, req_type, node_tag, node_owner, last_node, now,
        input  ready
    );
    modport sink (
        input  valid, req_type, node_tag, node_owner, last_node, now,
        output ready
    );
endinterface

`default_nettype wire

// File: rtl/core/rep_out_if.sv
// report channel interface
`default_nettype none

interface rep_out_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic        suppressed;
    logic [15:0] report_owner;
    logic [15:0] report_tag;
    logic [31:0] repeat_count;
    logic [31:0] event_sig;
    logic        last_result;

    modport source (
        output valid, kind, suppressed, report_owner, report_tag, repeat_count,
               event_sig, last_result,
        input  ready
    );
    modport sink (
        input  valid, kind, suppressed, report_owner, report_tag, repeat_count,
               event_sig, last_result,
        output ready
    );
endinterface

`default_nettype wire

// File: rtl/core/rep_datapath.sv
// datapath: signature fold, slot table, result staging and output register
`default_nettype none

module rep_datapath #(
    parameter int SLOT_COUNT = 8
) (
    input  wire                  clk,
    input  wire                  rst_n,
    rep_in_if.sink               node_ch,
    rep_out_if.source            report_ch,
    input  wire                  cfg_we,
    input  wire  [31:0]          cfg_wdata,
    input  wire rep_pkg::rep_cmd_t cmd,
    output rep_pkg::rep_status_t status
);

    localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(SLOT_COUNT - 1);

    logic [31:0] window_reg;
    logic        req_reg;
    logic [15:0] tag_reg;
    logic [15:0] owner_reg;
    logic        last_reg;
    logic [31:0] now_reg;
    logic [31:0] hash_reg;
    logic [15:0] first_tag_reg;
    logic [15:0] first_owner_reg;
    logic        mid_chain_reg;
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] tgt_reg;
    logic        tgt_used_reg;
    logic [31:0] tgt_since_reg;
    logic        supp_reg;
    logic [31:0] cnt_reg;

    logic [31:0] slot_sig_reg     [SLOT_COUNT];
    logic [15:0] slot_tag_reg     [SLOT_COUNT];
    logic [15:0] slot_owner_reg   [SLOT_COUNT];
    logic [31:0] slot_since_reg   [SLOT_COUNT];
    logic [31:0] slot_repeats_reg [SLOT_COUNT];

    logic                 pend_valid_reg;
    rep_pkg::rep_result_t pend_reg;
    logic                 out_valid_reg;
    rep_pkg::rep_result_t out_reg;

    logic        accept;
    logic [31:0] fold_in;
    logic [31:0] prod;
    logic [31:0] sig_w;
    logic [IDX_W-1:0] rd_idx;
    logic [31:0] cur_sig;
    logic [31:0] cur_since;
    logic [31:0] cur_rep;
    logic [31:0] rep_inc;
    logic [31:0] age;
    logic        look_match;
    logic        tgt_take;
    logic        emit;
    logic        emit_ok;
    rep_pkg::rep_result_t new_res;
    rep_pkg::rep_result_t out_load;

    assign accept    = node_ch.valid && cmd.take;
    assign node_ch.ready = cmd.take;

    assign fold_in   = cmd.fold_tag ? {16'd0, tag_reg} : {16'd0, owner_reg};
    assign prod      = (hash_reg ^ fold_in) * rep_pkg::FNV_PRIME;
    assign sig_w     = (hash_reg == 32'd0) ? 32'd1 : hash_reg;

    assign rd_idx    = cmd.use_target ? tgt_reg : idx_reg;
    assign cur_sig   = slot_sig_reg[idx_reg];
    assign cur_since = slot_since_reg[idx_reg];
    assign cur_rep   = slot_repeats_reg[idx_reg];
    assign rep_inc   = (cur_rep == 32'hFFFF_FFFF) ? cur_rep : cur_rep + 32'd1;
    assign age       = now_reg - cur_since;
    assign look_match = (cur_sig == sig_w);
    assign tgt_take  = (idx_reg == '0) || (cur_sig == 32'd0)
                     || (tgt_used_reg && (cur_since < tgt_since_reg));

    assign emit      = cmd.emit_summary || cmd.emit_verdict;
    assign emit_ok   = !pend_valid_reg || !out_valid_reg || report_ch.ready;

    always_comb
    begin
        if (cmd.emit_verdict)
        begin
            new_res.kind            = rep_pkg::KIND_VERDICT;
            new_res.suppressed      = supp_reg;
            new_res.report_owner    = first_owner_reg;
            new_res.report_tag      = first_tag_reg;
            new_res.repeat_count    = cnt_reg;
            new_res.event_sig       = sig_w;
        end
        else
        begin
            new_res.kind            = rep_pkg::KIND_SUMMARY;
            new_res.suppressed      = 1'b0;
            new_res.report_owner    = slot_owner_reg[rd_idx];
            new_res.report_tag      = slot_tag_reg[rd_idx];
            new_res.repeat_count    = slot_repeats_reg[rd_idx];
            new_res.event_sig       = slot_sig_reg[rd_idx];
        end
        new_res.last_result = 1'b0;
    end

    always_comb
    begin
        out_load             = pend_reg;
        out_load.last_result = cmd.flush;
    end

    always_comb
    begin
        status.in_valid      = node_ch.valid;
        status.in_tick       = node_ch.req_type;
        status.is_tick       = req_reg;
        status.is_last       = last_reg;
        status.window_zero   = (window_reg == 32'd0);
        status.idx_last      = (idx_reg == IDX_MAX);
        status.expire_hit    = (cur_sig != 32'd0) && (age >= window_reg);
        status.expire_report = (cur_rep != 32'd0);
        status.look_match    = look_match;
        status.target_report = (slot_sig_reg[tgt_reg] != 32'd0)
                             && (slot_repeats_reg[tgt_reg] != 32'd0);
        status.emit_ok       = emit_ok;
    end

    // control-side registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg     <= 32'd0;
            hash_reg       <= rep_pkg::FNV_OFFSET;
            mid_chain_reg  <= 1'b0;
            idx_reg        <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                window_reg <= cfg_wdata;

            if (accept && !node_ch.req_type)
                mid_chain_reg <= 1'b1;
            else if (cmd.chain_done)
                mid_chain_reg <= 1'b0;

            if (cmd.fold_tag || cmd.fold_owner)
                hash_reg <= prod;
            else if (cmd.chain_done)
                hash_reg <= rep_pkg::FNV_OFFSET;

            if (cmd.idx_clear)
                idx_reg <= '0;
            else if (cmd.idx_step)
                idx_reg <= idx_reg + IDX_W'(1);

            if (emit)
                pend_valid_reg <= 1'b1;
            else if (cmd.flush)
                pend_valid_reg <= 1'b0;

            if ((emit || cmd.flush) && pend_valid_reg)
                out_valid_reg <= 1'b1;
            else if (report_ch.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg   <= node_ch.req_type;
            tag_reg   <= node_ch.node_tag;
            owner_reg <= node_ch.node_owner;
            last_reg  <= node_ch.last_node;
            now_reg   <= node_ch.now;
            supp_reg  <= 1'b0;
            cnt_reg   <= 32'd0;
            if (!node_ch.req_type && !mid_chain_reg)
            begin
                first_tag_reg   <= node_ch.node_tag;
                first_owner_reg <= node_ch.node_owner;
            end
        end
        if (cmd.look_step)
        begin
            if (look_match)
            begin
                supp_reg <= 1'b1;
                cnt_reg  <= rep_inc;
            end
            else if (tgt_take)
            begin
                tgt_reg       <= idx_reg;
                tgt_used_reg  <= (cur_sig != 32'd0);
                tgt_since_reg <= cur_since;
            end
        end
        if (emit)
            pend_reg <= new_res;
        if ((emit || cmd.flush) && pend_valid_reg)
            out_reg <= out_load;
    end

    // slot table, signature and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOT_COUNT; i++)
            begin
                slot_sig_reg[i]     <= 32'd0;
                slot_repeats_reg[i] <= 32'd0;
            end
        end
        else
        begin
            if (cmd.expire_free)
            begin
                slot_sig_reg[idx_reg]     <= 32'd0;
                slot_repeats_reg[idx_reg] <= 32'd0;
            end
            if (cmd.look_step && look_match)
                slot_repeats_reg[idx_reg] <= rep_inc;
            if (cmd.fill)
            begin
                slot_sig_reg[tgt_reg]     <= sig_w;
                slot_repeats_reg[tgt_reg] <= 32'd0;
            end
        end
    end

    // slot table, stored fields
    always_ff @(posedge clk)
    begin
        if (cmd.fill)
        begin
            slot_tag_reg[tgt_reg]   <= first_tag_reg;
            slot_owner_reg[tgt_reg] <= first_owner_reg;
            slot_since_reg[tgt_reg] <= now_reg;
        end
    end

    assign report_ch.valid           = out_valid_reg;
    assign report_ch.kind            = out_reg.kind;
    assign report_ch.suppressed      = out_reg.suppressed;
    assign report_ch.report_owner    = out_reg.report_owner;
    assign report_ch.report_tag      = out_reg.report_tag;
    assign report_ch.repeat_count    = out_reg.repeat_count;
    assign report_ch.event_sig       = out_reg.event_sig;
    assign report_ch.last_result     = out_reg.last_result;

endmodule

`default_nettype wire

// File: rtl/core/rep_ctrl.sv
// controller state machine: fold, expiry scan, lookup scan, evict, verdict, flush
`default_nettype none

module rep_ctrl (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire rep_pkg::rep_status_t status,
    output rep_pkg::rep_cmd_t    cmd
);

    typedef enum logic [7:0] {
        ST_IDLE       = 8'b0000_0001,
        ST_HASH_TAG   = 8'b0000_0010,
        ST_HASH_OWNER = 8'b0000_0100,
        ST_EXPIRE     = 8'b0000_1000,
        ST_LOOKUP     = 8'b0001_0000,
        ST_EVICT      = 8'b0010_0000,
        ST_VERDICT    = 8'b0100_0000,
        ST_FLUSH      = 8'b1000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.take = 1'b1;
                if (status.in_valid)
                begin
                    cmd.idx_clear = 1'b1;
                    state_next = status.in_tick ? ST_EXPIRE : ST_HASH_TAG;
                end
            end
            ST_HASH_TAG:
            begin
                cmd.fold_tag = 1'b1;
                state_next   = ST_HASH_OWNER;
            end
            ST_HASH_OWNER:
            begin
                cmd.fold_owner = 1'b1;
                state_next     = status.is_last ? ST_EXPIRE : ST_IDLE;
            end
            ST_EXPIRE:
            begin
                if (!(status.expire_hit && status.expire_report && !status.emit_ok))
                begin
                    cmd.expire_free  = status.expire_hit;
                    cmd.emit_summary = status.expire_hit && status.expire_report;
                    if (status.idx_last)
                    begin
                        cmd.idx_clear = 1'b1;
                        if (status.is_tick)
                            state_next = ST_FLUSH;
                        else if (status.window_zero)
                            state_next = ST_VERDICT;
                        else
                            state_next = ST_LOOKUP;
                    end
                    else
                        cmd.idx_step = 1'b1;
                end
            end
            ST_LOOKUP:
            begin
                cmd.look_step = 1'b1;
                if (status.look_match)
                    state_next = ST_VERDICT;
                else if (status.idx_last)
                    state_next = ST_EVICT;
                else
                    cmd.idx_step = 1'b1;
            end
            ST_EVICT:
            begin
                cmd.use_target = 1'b1;
                if (!(status.target_report && !status.emit_ok))
                begin
                    cmd.fill         = 1'b1;
                    cmd.emit_summary = status.target_report;
                    state_next       = ST_VERDICT;
                end
            end
            ST_VERDICT:
            begin
                if (status.emit_ok)
                begin
                    cmd.emit_verdict = 1'b1;
                    state_next       = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                if (status.emit_ok)
                begin
                    cmd.flush      = 1'b1;
                    cmd.chain_done = !status.is_tick;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/core/repeat_event_suppressor.sv
// Repeat event suppressor top level. One transaction at a time: a node that does
// not end its chain is accepted and then takes two hash multiplies, a tick runs the
// expiry scan and then a flush, and a chain's last node runs the two multiplies, the
// expiry scan, at most the lookup scan and evict, then verdict and flush. Each scan
// checks one slot per cycle, the expiry scan only while no summary is stalled; a
// slow report sink adds stalls. Reports pass through a staging register and an
// output register, and the final report of each transaction has last_result set.
// The slot table is in flip-flops; its signatures and counts are cleared by reset.
`default_nettype none

module repeat_event_suppressor #(
    parameter int SLOT_COUNT = 8
) (
    input  wire        clk,
    input  wire        rst_n,
    rep_in_if.sink     node_ch,
    rep_out_if.source  report_ch,
    input  wire        cfg_we,
    input  wire [31:0] cfg_wdata
);

    rep_pkg::rep_cmd_t    cmd;
    rep_pkg::rep_status_t status;

    rep_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .cmd    (cmd)
    );

    rep_datapath #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .node_ch   (node_ch),
        .report_ch (report_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

`default_nettype wire

// File: rtl/core/rep_checker.sv
// port checker for the repeat event suppressor and its bind
`default_nettype none

module rep_checker (
    input wire        clk,
    input wire        rst_n,
    input wire        in_valid,
    input wire        in_ready,
    input wire        out_valid,
    input wire        out_ready,
    input wire        kind,
    input wire        suppressed,
    input wire [31:0] repeat_count,
    input wire [31:0] event_sig,
    input wire        last_result
);

    // stalled report holds its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=>
            (out_valid && $stable(event_sig) && $stable(repeat_count)
             && $stable(last_result)))
        else $error("report changed while stalled");

    // one transaction at a time
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("new transaction taken while busy");

    // a verdict closes its transaction
    a_verdict_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && kind == rep_pkg::KIND_VERDICT) |-> last_result)
        else $error("verdict without last_result");

    // summaries are never suppressed and always carry repeats
    a_summary_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && kind == rep_pkg::KIND_SUMMARY) |->
            (!suppressed && repeat_count != 32'd0))
        else $error("malformed summary");

    a_sig_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (event_sig != 32'd0))
        else $error("zero signature reported");

endmodule

bind repeat_event_suppressor rep_checker u_rep_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (node_ch.valid),
    .in_ready        (node_ch.ready),
    .out_valid       (report_ch.valid),
    .out_ready       (report_ch.ready),
    .kind            (report_ch.kind),
    .suppressed      (report_ch.suppressed),
    .repeat_count    (report_ch.repeat_count),
    .event_sig       (report_ch.event_sig),
    .last_result     (report_ch.last_result)
);

`default_nettype wire
